/* design/bmp_pkg.sv */
// shared types and constants for the bitmap pixel extractor
package bmp_pkg;

    // largest image accepted
    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;

    // counter widths follow the size limits
    localparam int unsigned COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // output field widths
    localparam int unsigned COLOR_W  = 8;
    localparam int unsigned COORD_W  = 12;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned HDR_W    = 6;

    // header byte positions
    localparam logic [HDR_W-1:0] HDR_SIG0      = 6'd0;
    localparam logic [HDR_W-1:0] HDR_SIG1      = 6'd1;
    localparam logic [HDR_W-1:0] HDR_FILE_LAST = 6'd13;
    localparam logic [HDR_W-1:0] HDR_WIDTH_LO  = 6'd18;
    localparam logic [HDR_W-1:0] HDR_WIDTH_HI  = 6'd21;
    localparam logic [HDR_W-1:0] HDR_HEIGHT_LO = 6'd22;
    localparam logic [HDR_W-1:0] HDR_HEIGHT_HI = 6'd25;
    localparam logic [HDR_W-1:0] HDR_DEPTH_LO  = 6'd26;
    localparam logic [HDR_W-1:0] HDR_DEPTH_HI  = 6'd27;
    localparam logic [HDR_W-1:0] HDR_INFO_LAST = 6'd53;

    // signature and depth values
    localparam logic [7:0]  SIG_B      = 8'h42;
    localparam logic [7:0]  SIG_M      = 8'h4D;
    localparam logic [15:0] DEPTH_RGB  = 16'd24;
    localparam logic [31:0] WIDTH_MAX  = 32'(MAX_WIDTH);
    localparam logic [31:0] HEIGHT_MAX = 32'(MAX_HEIGHT);

    // parser phase
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_PAD,
        PH_IDLE
    } t_phase;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_PIXEL,
        ST_BADSIG,
        ST_BADDEPTH,
        ST_BADSIZE
    } t_status;

    // one result item
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last_pixel;
        t_status            status;
    } t_result;

endpackage

/* design/bmp_if.sv */
// stream channel interfaces for file bytes and pixel results
interface bmp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface bmp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_pixel;
    logic [1:0]  status;

    modport source (output valid, output red, output green, output blue,
                    output column, output row, output last_pixel, output status,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input column, input row, input last_pixel, input status,
                    output ready);
endinterface

/* design/bmp_parse.sv */
// header parser and pixel assembler, one byte per accepted request
module bmp_parse import bmp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase             r_phase,  n_phase,  e_phase;
    logic [HDR_W-1:0]   r_hdr,    n_hdr,    e_hdr;
    logic               r_sig,    n_sig,    e_sig;
    logic [31:0]        r_width,  n_width,  e_width;
    logic [31:0]        r_height, n_height, e_height;
    logic [15:0]        r_depth,  n_depth,  e_depth;
    logic [1:0]         r_bip,    n_bip,    e_bip;
    logic [7:0]         r_blue,   n_blue;
    logic [7:0]         r_green,  n_green;
    logic [COL_W-1:0]   r_col,    n_col,    e_col;
    logic [ROW_W-1:0]   r_row,    n_row,    e_row;
    logic [1:0]         r_pad,    n_pad,    e_pad;

    logic [1:0]         lane;
    logic               last_col;
    logic               last_row;
    logic               size_bad;

    // state registers, advanced on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hdr    <= '0;
            r_sig    <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
            r_depth  <= '0;
            r_bip    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_pad    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_hdr    <= n_hdr;
            r_sig    <= n_sig;
            r_width  <= n_width;
            r_height <= n_height;
            r_depth  <= n_depth;
            r_bip    <= n_bip;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pad    <= n_pad;
        end
    end

    // held color bytes
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_blue  <= n_blue;
            r_green <= n_green;
        end
    end

    // a first-byte mark restarts parsing from the reset state
    always_comb begin
        e_phase  = i_first_byte ? PH_HEADER : r_phase;
        e_hdr    = i_first_byte ? '0 : r_hdr;
        e_sig    = i_first_byte ? 1'b0 : r_sig;
        e_width  = i_first_byte ? '0 : r_width;
        e_height = i_first_byte ? '0 : r_height;
        e_depth  = i_first_byte ? '0 : r_depth;
        e_bip    = i_first_byte ? '0 : r_bip;
        e_col    = i_first_byte ? '0 : r_col;
        e_row    = i_first_byte ? '0 : r_row;
        e_pad    = i_first_byte ? '0 : r_pad;
    end

    // byte lane within a 32-bit size field
    always_comb begin
        if (e_hdr <= HDR_WIDTH_HI) begin
            lane = 2'(e_hdr - HDR_WIDTH_LO);
        end else begin
            lane = 2'(e_hdr - HDR_HEIGHT_LO);
        end
    end

    // end of row and end of image
    assign last_col = (32'(e_col) + 32'd1) >= e_width;
    assign last_row = (32'(e_row) + 32'd1) >= e_height;

    // next state and result
    always_comb begin
        n_phase  = e_phase;
        n_hdr    = e_hdr;
        n_sig    = e_sig;
        n_width  = e_width;
        n_height = e_height;
        n_depth  = e_depth;
        n_bip    = e_bip;
        n_blue   = r_blue;
        n_green  = r_green;
        n_col    = e_col;
        n_row    = e_row;
        n_pad    = e_pad;
        o_res_valid = 1'b0;
        o_res       = '0;
        size_bad    = 1'b0;

        unique case (e_phase)
            PH_HEADER: begin
                n_hdr = e_hdr + 1'b1;
                // capture header fields
                priority if (e_hdr == HDR_SIG0) begin
                    n_sig = (i_data_byte == SIG_B);
                end else if (e_hdr == HDR_SIG1) begin
                    n_sig = e_sig & (i_data_byte == SIG_M);
                end else if (e_hdr >= HDR_WIDTH_LO && e_hdr <= HDR_WIDTH_HI) begin
                    n_width = e_width | (32'(i_data_byte) << {lane, 3'b000});
                end else if (e_hdr >= HDR_HEIGHT_LO && e_hdr <= HDR_HEIGHT_HI) begin
                    n_height = e_height | (32'(i_data_byte) << {lane, 3'b000});
                end else if (e_hdr == HDR_DEPTH_LO) begin
                    n_depth = {e_depth[15:8], i_data_byte};
                end else if (e_hdr == HDR_DEPTH_HI) begin
                    n_depth = {i_data_byte, e_depth[7:0]};
                end else begin
                    n_sig = e_sig;
                end

                size_bad = (e_width == 32'd0) || (e_width > WIDTH_MAX) ||
                           (e_height == 32'd0) || (e_height > HEIGHT_MAX);

                // checks at the end of each header
                priority if (e_hdr == HDR_FILE_LAST && !e_sig) begin
                    o_res_valid   = 1'b1;
                    o_res.status  = ST_BADSIG;
                    n_phase       = PH_IDLE;
                end else if (e_hdr == HDR_INFO_LAST && e_depth != DEPTH_RGB) begin
                    o_res_valid   = 1'b1;
                    o_res.status  = ST_BADDEPTH;
                    n_phase       = PH_IDLE;
                end else if (e_hdr == HDR_INFO_LAST && size_bad) begin
                    o_res_valid   = 1'b1;
                    o_res.status  = ST_BADSIZE;
                    n_phase       = PH_IDLE;
                end else if (e_hdr == HDR_INFO_LAST) begin
                    n_phase = PH_PIXEL;
                    n_bip   = '0;
                    n_col   = '0;
                    n_row   = '0;
                end else begin
                    n_phase = e_phase;
                end
            end

            PH_PIXEL: begin
                priority if (e_bip == 2'd0) begin
                    n_blue = i_data_byte;
                    n_bip  = 2'd1;
                end else if (e_bip == 2'd1) begin
                    n_green = i_data_byte;
                    n_bip   = 2'd2;
                end else begin
                    // red byte completes the pixel
                    n_bip             = 2'd0;
                    o_res_valid       = 1'b1;
                    o_res.red         = i_data_byte;
                    o_res.green       = r_green;
                    o_res.blue        = r_blue;
                    o_res.column      = COORD_W'(e_col);
                    o_res.row         = COORD_W'(e_row);
                    o_res.last_pixel  = last_col && last_row;
                    o_res.status      = ST_PIXEL;
                    priority if (last_col && last_row) begin
                        n_phase = PH_IDLE;
                    end else if (last_col) begin
                        n_col = '0;
                        n_pad = e_width[1:0];
                        if (e_width[1:0] != 2'd0) begin
                            n_phase = PH_PAD;
                        end else begin
                            n_row = e_row + 1'b1;
                        end
                    end else begin
                        n_col = e_col + 1'b1;
                    end
                end
            end

            PH_PAD: begin
                n_pad = e_pad - 2'd1;
                if (n_pad == 2'd0) begin
                    n_row   = e_row + 1'b1;
                    n_phase = PH_PIXEL;
                    n_bip   = 2'd0;
                end
            end

            PH_IDLE: begin
                n_phase = PH_IDLE;
            end

            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

endmodule

/* design/bmp_out_reg.sv */
// result register between the parser and the output channel
module bmp_out_reg import bmp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    // room for a new result when empty or being taken this cycle
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* design/bmp24_stream_pixel_extractor.sv */
// top level of the 24-bit bitmap stream pixel extractor
// a result appears on the output in the cycle after the byte that completes it is taken
// throughput: one file byte per cycle unless a stalled result holds the single result register
// a byte is taken whenever the result register is empty or being drained
// reset (synchronous, active low) leaves the parser waiting for byte 0 of a file
// and the result register empty
module bmp24_stream_pixel_extractor import bmp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bmp_in_if.sink    i_in,
    bmp_out_if.source o_out
);

    logic    step;
    logic    res_valid;
    logic    free;
    t_result res;
    t_result out_res;

    // take a byte when the result register can hold what it causes
    assign i_in.ready = free;
    assign step       = i_in.valid && free;

    bmp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_data_byte  (i_in.data_byte),
        .i_first_byte (i_in.first_byte),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    bmp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (res),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_free  (free),
        .o_res   (out_res)
    );

    // output payload
    assign o_out.red        = out_res.red;
    assign o_out.green      = out_res.green;
    assign o_out.blue       = out_res.blue;
    assign o_out.column     = out_res.column;
    assign o_out.row        = out_res.row;
    assign o_out.last_pixel = out_res.last_pixel;
    assign o_out.status     = out_res.status;

`ifndef SYNTHESIS
    // no byte is taken while a stalled result still occupies the register
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("byte accepted while result stalled");

    // error results carry zero pixel fields
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_PIXEL) |->
        (o_out.red == 8'd0 && o_out.green == 8'd0 && o_out.blue == 8'd0 &&
         o_out.column == 12'd0 && o_out.row == 12'd0 && !o_out.last_pixel))
        else $error("error result with nonzero pixel fields");

    // a delivered result leaves the register empty unless a new one was loaded
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !i_in.valid) |=> !o_out.valid)
        else $error("result repeated after hand-off");
`endif

endmodule

/* tb/bmp24_pixel_checker.sv */
// pixel checker: follows the byte and pixel channels, predicts each result and compares it
`timescale 1ns / 1ps

module bmp24_pixel_checker import bmp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bmp_in_if    i_in_mon,
    bmp_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_results_due
);

    localparam int PRINT_CAP = 40;

    // parser state of the predictor
    t_phase      ph;
    logic [5:0]  hdr_cnt;
    logic        sig_ok;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [15:0] depth;
    logic [1:0]  pix_byte;
    logic [7:0]  blue_hold;
    logic [7:0]  green_hold;
    logic [31:0] col_cnt;
    logic [31:0] row_cnt;
    logic [1:0]  pad_left;

    // pixels and error reports still owed by the block, oldest first
    t_result pixel_results_due[$];

    int fail_count   = 0;
    int results_seen = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP) begin
            $display("[%0t] checker: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d field %s: got %0h want %0h",
                                      results_seen, name, got, want));
        end
    endtask

    task automatic restart_parse();
        ph         = PH_HEADER;
        hdr_cnt    = '0;
        sig_ok     = 1'b0;
        img_w      = '0;
        img_h      = '0;
        depth      = '0;
        pix_byte   = '0;
        blue_hold  = '0;
        green_hold = '0;
        col_cnt    = '0;
        row_cnt    = '0;
        pad_left   = '0;
    endtask

    // header fault: all-zero result carrying the status, then idle
    task automatic flag_error(input t_status st);
        t_result px;
        px        = '0;
        px.status = st;
        pixel_results_due = {pixel_results_due, px};
        ph = PH_IDLE;
    endtask

    // advance the parser by one file byte and queue whatever it yields
    task automatic parse_file_byte(input logic [7:0] b, input logic mark);
        t_result px;
        logic    last_col;
        logic    last_row;
        if (mark) begin
            restart_parse();
        end
        case (ph)
            PH_HEADER: begin
                // capture signature and little-endian info header fields
                if (hdr_cnt == HDR_SIG0) begin
                    sig_ok = (b == SIG_B);
                end else if (hdr_cnt == HDR_SIG1) begin
                    if (b != SIG_M) begin
                        sig_ok = 1'b0;
                    end
                end else if (hdr_cnt >= HDR_WIDTH_LO && hdr_cnt <= HDR_WIDTH_HI) begin
                    img_w |= 32'(b) << (8 * (hdr_cnt - HDR_WIDTH_LO));
                end else if (hdr_cnt >= HDR_HEIGHT_LO && hdr_cnt <= HDR_HEIGHT_HI) begin
                    img_h |= 32'(b) << (8 * (hdr_cnt - HDR_HEIGHT_LO));
                end else if (hdr_cnt == HDR_DEPTH_LO) begin
                    depth[7:0] = b;
                end else if (hdr_cnt == HDR_DEPTH_HI) begin
                    depth[15:8] = b;
                end
                // signature checked at end of file header, depth before size at end of info
                if (hdr_cnt == HDR_FILE_LAST && !sig_ok) begin
                    flag_error(ST_BADSIG);
                end else if (hdr_cnt == HDR_INFO_LAST) begin
                    if (depth != DEPTH_RGB) begin
                        flag_error(ST_BADDEPTH);
                    end else if (img_w == 0 || img_w > WIDTH_MAX ||
                                 img_h == 0 || img_h > HEIGHT_MAX) begin
                        flag_error(ST_BADSIZE);
                    end else begin
                        ph       = PH_PIXEL;
                        pix_byte = '0;
                        col_cnt  = '0;
                        row_cnt  = '0;
                    end
                end
                hdr_cnt = hdr_cnt + 1'b1;
            end
            PH_PIXEL: begin
                // blue, green, red triple
                if (pix_byte == 2'd0) begin
                    blue_hold = b;
                    pix_byte  = 2'd1;
                end else if (pix_byte == 2'd1) begin
                    green_hold = b;
                    pix_byte   = 2'd2;
                end else begin
                    pix_byte      = 2'd0;
                    last_col      = (col_cnt + 1) >= img_w;
                    last_row      = (row_cnt + 1) >= img_h;
                    px.red        = b;
                    px.green      = green_hold;
                    px.blue       = blue_hold;
                    px.column     = col_cnt[COORD_W-1:0];
                    px.row        = row_cnt[COORD_W-1:0];
                    px.last_pixel = last_col && last_row;
                    px.status     = ST_PIXEL;
                    pixel_results_due = {pixel_results_due, px};
                    if (px.last_pixel) begin
                        ph = PH_IDLE;
                    end else if (last_col) begin
                        col_cnt  = '0;
                        pad_left = img_w[1:0];
                        if (pad_left != 2'd0) begin
                            ph = PH_PAD;
                        end else begin
                            row_cnt++;
                        end
                    end else begin
                        col_cnt++;
                    end
                end
            end
            PH_PAD: begin
                // skip row padding
                pad_left = pad_left - 1'b1;
                if (pad_left == 2'd0) begin
                    row_cnt++;
                    ph       = PH_PIXEL;
                    pix_byte = '0;
                end
            end
            default: ;
        endcase
    endtask

    // compare delivered results first, then predict from the accepted byte
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            restart_parse();
            pixel_results_due.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (pixel_results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: status %0d col %0d row %0d",
                                              i_out_mon.status, i_out_mon.column,
                                              i_out_mon.row));
                end else begin
                    want = pixel_results_due.pop_front();
                    check_field("status", i_out_mon.status, want.status);
                    check_field("red", i_out_mon.red, want.red);
                    check_field("green", i_out_mon.green, want.green);
                    check_field("blue", i_out_mon.blue, want.blue);
                    check_field("column", i_out_mon.column, want.column);
                    check_field("row", i_out_mon.row, want.row);
                    check_field("last_pixel", i_out_mon.last_pixel, want.last_pixel);
                end
                results_seen++;
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                parse_file_byte(i_in_mon.data_byte, i_in_mon.first_byte);
            end
        end
        o_results_due <= pixel_results_due.size();
    end

endmodule

/* tb/bmp24_stream_pixel_extractor_tb.sv */
// testbench top: bitmap file stimulus, receiver stalls, run limit and verdict
`timescale 1ns / 1ps

module bmp24_stream_pixel_extractor_tb import bmp_pkg::*;;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int RANDOM_BYTES = 600;
    localparam int HDR_BYTES    = 54;
    localparam int NO_STOP      = -1;
    localparam int RANDOM_FILL  = -1;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // sender and receiver drive points
    logic       tx_valid = 1'b0;
    logic [7:0] tx_byte  = '0;
    logic       tx_first = 1'b0;
    logic       rx_ready = 1'b0;

    int          fail_count;
    int          results_due;
    int          bytes_sent  = 0;
    int          burst_left  = 0;
    int unsigned cycle_count = 0;

    bmp_in_if  in_ch ();
    bmp_out_if out_ch ();

    assign in_ch.valid      = tx_valid;
    assign in_ch.data_byte  = tx_byte;
    assign in_ch.first_byte = tx_first;
    assign out_ch.ready     = rx_ready;

    bmp24_stream_pixel_extractor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    bmp24_pixel_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: ready follows a 16-bit mask, stepped bit by bit and chosen anew after a random span
    logic [15:0] stall_mask = 16'hFFFF;
    logic [3:0]  stall_pos  = '0;
    int          stall_span = 0;

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_span <= $urandom_range(50, 400);
            case ($urandom_range(0, 3))
                0: stall_mask <= 16'hFFFF;
                1: stall_mask <= 16'($urandom) | 16'h0001;
                2: stall_mask <= 16'h0101 << $urandom_range(0, 7);
                default: stall_mask <= 16'hAAAA;
            endcase
        end else begin
            stall_span <= stall_span - 1;
        end
        stall_pos <= stall_pos + 1'b1;
        rx_ready  <= stall_mask[stall_pos];
    end

    // one byte request, sent in bursts with random gaps between them
    task automatic send_byte(input logic [7:0] b, input logic mark);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                      : $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                tx_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        tx_valid <= 1'b1;
        tx_byte  <= b;
        tx_first <= mark;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    // hold off the sender until every owed result has been delivered
    task automatic wait_results_drained();
        tx_valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
    endtask

    // whole bitmap file; pixel data only when the header is acceptable,
    // stop_at cuts the file short after that many bytes
    task automatic send_file(input logic [31:0] w, input logic [31:0] h,
                             input logic [15:0] bpp, input logic [7:0] sig0,
                             input logic [7:0] sig1, input logic mark,
                             input int fill, input int stop_at);
        logic [7:0] hdr [HDR_BYTES];
        logic       good;
        int         sent;
        int         row_bytes;
        for (int i = 0; i < HDR_BYTES; i++) begin
            hdr[i] = 8'($urandom);
        end
        hdr[HDR_SIG0] = sig0;
        hdr[HDR_SIG1] = sig1;
        for (int i = 0; i < 4; i++) begin
            hdr[HDR_WIDTH_LO + i]  = w[8*i +: 8];
            hdr[HDR_HEIGHT_LO + i] = h[8*i +: 8];
        end
        hdr[HDR_DEPTH_LO] = bpp[7:0];
        hdr[HDR_DEPTH_HI] = bpp[15:8];
        good = sig0 == SIG_B && sig1 == SIG_M && bpp == DEPTH_RGB &&
               w >= 1 && w <= WIDTH_MAX && h >= 1 && h <= HEIGHT_MAX;
        sent = 0;
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (sent == stop_at) return;
            send_byte(hdr[i], mark && i == 0);
            sent++;
        end
        if (!good) return;
        row_bytes = 3 * int'(w) + int'(w[1:0]);
        for (int r = 0; r < int'(h); r++) begin
            for (int k = 0; k < row_bytes; k++) begin
                if (sent == stop_at) return;
                if (k < 3 * int'(w) && fill >= 0) begin
                    send_byte(8'(fill), 1'b0);
                end else begin
                    send_byte(8'($urandom), 1'b0);
                end
                sent++;
            end
        end
    endtask

    initial begin
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] bpp;
        logic [7:0]  s0;
        logic [7:0]  s1;
        int          kind;
        int          total;
        int          random_start;

        // reset
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first file without a restart mark right after reset
        send_file(2, 2, DEPTH_RGB, SIG_B, SIG_M, 1'b0, RANDOM_FILL, NO_STOP);
        // signature faults, bytes after the fault are ignored
        send_file(2, 1, DEPTH_RGB, 8'h58, SIG_M, 1'b1, RANDOM_FILL, 20);
        send_file(2, 1, DEPTH_RGB, SIG_B, 8'h4E, 1'b1, RANDOM_FILL, NO_STOP);
        send_file(2, 1, DEPTH_RGB, SIG_M, SIG_B, 1'b1, RANDOM_FILL, 14);
        // depth faults, one with a nonzero high byte over a 24 low byte
        send_file(2, 1, 16'h0118, SIG_B, SIG_M, 1'b1, RANDOM_FILL, NO_STOP);
        send_file(2, 1, 16'h1800, SIG_B, SIG_M, 1'b1, RANDOM_FILL, NO_STOP);
        send_file(2, 1, 16'd32, SIG_B, SIG_M, 1'b1, RANDOM_FILL, NO_STOP);
        // size faults: zero, one past the limit, top-down height, high byte set
        send_file(0, 2, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, NO_STOP);
        send_file(WIDTH_MAX + 1, 2, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, NO_STOP);
        send_file(2, 32'hFFFF_FFFF, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, NO_STOP);
        send_file(32'h0100_0003, 2, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, NO_STOP);
        send_file(3, 0, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, NO_STOP);
        send_file(3, HEIGHT_MAX + 1, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, NO_STOP);
        // every padding length, all-zero and all-one pixels
        send_file(1, 3, DEPTH_RGB, SIG_B, SIG_M, 1'b1, 0, NO_STOP);
        send_file(3, 2, DEPTH_RGB, SIG_B, SIG_M, 1'b1, 255, NO_STOP);
        send_file(4, 2, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, NO_STOP);
        send_file(5, 1, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, NO_STOP);
        send_file(6, 2, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, NO_STOP);
        // trailing bytes after the last pixel
        repeat (3) send_byte(8'($urandom), 1'b0);
        // restart in the middle of a pixel, then in the middle of the header
        send_file(3, 3, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, HDR_BYTES + 5);
        send_file(2, 2, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, 20);
        send_file(2, 1, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, NO_STOP);
        // largest sizes are accepted, cut short after a few pixels
        send_file(WIDTH_MAX, 1, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, HDR_BYTES + 30);
        send_file(1, HEIGHT_MAX, DEPTH_RGB, SIG_B, SIG_M, 1'b1, RANDOM_FILL, HDR_BYTES + 40);
        wait_results_drained();

        // random files, mostly well formed with small sizes
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            w   = $urandom_range(1, 6);
            h   = $urandom_range(1, 4);
            bpp = DEPTH_RGB;
            s0  = SIG_B;
            s1  = SIG_M;
            if ($urandom_range(0, 19) == 0) begin
                w = $urandom_range(7, 48);
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_file(w, h, bpp, s0, s1, 1'b1, RANDOM_FILL, NO_STOP);
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
            end else if (kind < 78) begin
                // cut short, the next file restarts the parser
                total = HDR_BYTES + int'(h) * (3 * int'(w) + int'(w[1:0]));
                send_file(w, h, bpp, s0, s1, 1'b1, RANDOM_FILL,
                          $urandom_range(1, total - 1));
            end else if (kind < 84) begin
                do begin
                    if ($urandom_range(0, 1) == 0) begin
                        s0 = 8'($urandom);
                    end else begin
                        s1 = 8'($urandom);
                    end
                end while (s0 == SIG_B && s1 == SIG_M);
                send_file(w, h, bpp, s0, s1, 1'b1, RANDOM_FILL,
                          HDR_FILE_LAST + 1 + $urandom_range(0, 4));
            end else if (kind < 90) begin
                do begin
                    if ($urandom_range(0, 1) == 0) begin
                        bpp = 16'($urandom);
                    end else begin
                        bpp = {8'($urandom_range(1, 255)), DEPTH_RGB[7:0]};
                    end
                end while (bpp == DEPTH_RGB);
                send_file(w, h, bpp, s0, s1, 1'b1, RANDOM_FILL, NO_STOP);
            end else if (kind < 95) begin
                case ($urandom_range(0, 3))
                    0: w = 0;
                    1: w = $urandom_range(WIDTH_MAX + 1, 200000);
                    2: h = 32'($urandom) | 32'h8000_0000;
                    default: h = $urandom_range(HEIGHT_MAX + 1, 70000);
                endcase
                send_file(w, h, bpp, s0, s1, 1'b1, RANDOM_FILL, NO_STOP);
            end else begin
                // noise, now and then with a restart mark
                repeat ($urandom_range(1, 8)) begin
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                end
            end
            if ($urandom_range(0, 24) == 0) begin
                wait_results_drained();
            end
        end

        // drain, allow for the output register, then verdict
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
